// ===== design/steering_command_arbiter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Steering command arbiter assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEERING_COMMAND_ARBITER_UNIT_MACROS_SVH
`define STEERING_COMMAND_ARBITER_UNIT_MACROS_SVH

`ifndef SYNTH
// Condition holds at every clock edge out of reset.
`define SCA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sca assertion failed");
// Antecedent at one edge implies consequent at the same edge.
`define SCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sca implication failed");
// Antecedent at one edge implies consequent at the next edge.
`define SCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sca next-cycle check failed");
`else
`define SCA_ASSERT(lbl, cond)
`define SCA_ASSERT_IMP(lbl, ante, cons)
`define SCA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/sca_pkg.sv =====
// ----------------------------------------------------------------------------
// Steering command arbiter package
// Shared codes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;

  // request types
  localparam logic [2:0] REQ_BUS_WRITE = 3'd0;
  localparam logic [2:0] REQ_REMOTE    = 3'd1;
  localparam logic [2:0] REQ_TICK      = 3'd2;
  localparam logic [2:0] REQ_DISP_DONE = 3'd3;
  localparam logic [2:0] REQ_STEER_POS = 3'd4;

  // bus register targets
  localparam logic [7:0] BUS_SPEED     = 8'd0;
  localparam logic [7:0] BUS_DIRECTION = 8'd1;
  localparam logic [7:0] BUS_MANEUVER  = 8'd2;

  // emitted event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SPEED = 2'd1;
  localparam logic [1:0] EV_STEER = 2'd2;
  localparam logic [1:0] EV_DISP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFF  = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_NEUTRAL   = 8'd128;
  localparam logic [6:0] RST_THRESHOLD = 7'd10;
  localparam logic [7:0] RST_TICKS     = 8'd35;
  localparam logic [6:0] RST_DIST_OFF  = 7'd95;
  localparam logic [6:0] RST_TURN_OFF  = 7'd90;

  localparam logic [2:0] MAX_MANEUVER = 3'd5;

  // servo timer arithmetic
  localparam logic [15:0] PWM_BIAS      = 16'd2000;
  localparam logic [15:0] PWM_LOW_BASE  = 16'd25535;
  localparam logic [15:0] PWM_HIGH_BASE = 16'd65535;

endpackage

`default_nettype wire

// ===== design/sca_if.sv =====
// ----------------------------------------------------------------------------
// Steering command arbiter channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sca_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] bus_register;
  logic       remote_channel;
  logic [7:0] value;

  modport source (output valid, req_type, bus_register, remote_channel, value,
                  input ready);
  modport sink   (input valid, req_type, bus_register, remote_channel, value,
                  output ready);
endinterface

interface sca_res_if #(parameter int CntW = 5);
  logic            valid;
  logic            ready;
  logic [1:0]      event_kind;
  logic [7:0]      event_value;
  logic            to_internal_queue;
  logic            pwm_valid;
  logic [15:0]     pwm_low_time;
  logic [15:0]     pwm_high_time;
  logic            control_mode;
  logic [CntW-1:0] pending_count;
  logic [7:0]      inactivity_left;
  logic [7:0]      last_received_maneuver;
  logic            last_of_run;

  modport source (output valid, event_kind, event_value, to_internal_queue, pwm_valid,
                  pwm_low_time, pwm_high_time, control_mode, pending_count,
                  inactivity_left, last_received_maneuver, last_of_run,
                  input ready);
  modport sink   (input valid, event_kind, event_value, to_internal_queue, pwm_valid,
                  pwm_low_time, pwm_high_time, control_mode, pending_count,
                  inactivity_left, last_received_maneuver, last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== design/sca_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ram #(
  parameter int Width = 3,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/steering_command_arbiter_unit.sv =====
// ----------------------------------------------------------------------------
// Steering command arbiter
// Arbitrates speed/steering control between a radio remote and a command bus.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  - request items (bus write, remote reading, tick, displacement
//            reached, steering position); transfer on valid && ready.
//   res_o  - result items; one per request, two for a maneuver pop (the
//            displacement demand, then the wheel-angle demand, last_of_run=1).
//   cfg_*  - register write port, to be written only while the block is idle;
//            the block itself does not enforce this.
// Path: a request is held in the input register, then its result is offered
//   from the result register.
// Throughput: one request per cycle while results are taken every cycle; a
//   maneuver pop occupies the single result port for both of its results, so
//   the next request is processed only as the second one leaves. The result
//   register plus a one-entry second-result slot set this rate.
// Stall: while res_o.ready is low the result stays put, one more request is
//   held in the input register, then req_i.ready drops.
// Reset: mode goes to remote, countdown to 35, queue empty, registers to
//   their defaults. The maneuver RAM is not cleared (fill count guards it),
//   so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "steering_command_arbiter_unit_macros.svh"

module steering_command_arbiter_unit #(
  parameter int QUEUE_DEPTH = sca_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sca_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sca_req_if.sink                            req_i,
  sca_res_if.source                          res_o
);

  import sca_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       value;
    logic             internal;
    logic             pwm_valid;
    logic [15:0]      pwm_lo;
    logic [15:0]      pwm_hi;
    logic             mode;
    logic [CNT_W-1:0] pending;
    logic [7:0]       inact;
    logic [7:0]       last_man;
    logic             last;
  } res_t;

  // ---------------- configuration registers ----------------
  logic [7:0] neutral_q, ticks_q;
  logic [6:0] thresh_q, dist_off_q, turn_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q  <= RST_NEUTRAL;
      thresh_q   <= RST_THRESHOLD;
      ticks_q    <= RST_TICKS;
      dist_off_q <= RST_DIST_OFF;
      turn_off_q <= RST_TURN_OFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEUTRAL:   neutral_q  <= cfg_data_i;
        CFG_THRESHOLD: thresh_q   <= cfg_data_i[6:0];
        CFG_TICKS:     ticks_q    <= cfg_data_i;
        CFG_DIST_OFF:  dist_off_q <= cfg_data_i[6:0];
        CFG_TURN_OFF:  turn_off_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake and stage control ----------------
  logic       in_valid_q;
  logic [2:0] req_type_q;
  logic [7:0] bus_reg_q;
  logic       chan_q;
  logic [7:0] value_q;

  logic out_valid_q, pend_valid_q;
  res_t out_q, pend_q;

  logic in_fire, out_fire, load;

  assign out_fire = out_valid_q && res_o.ready;
  // process the held request when both result slots will be free
  assign load = in_valid_q && !pend_valid_q && (!out_valid_q || out_fire);
  assign req_i.ready = !in_valid_q || load;
  assign in_fire = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_type_q <= req_i.req_type;
      bus_reg_q  <= req_i.bus_register;
      chan_q     <= req_i.remote_channel;
      value_q    <= req_i.value;
    end
  end

  // ---------------- arbiter state ----------------
  logic             mode_q, mode_d;
  logic [7:0]       inact_q, inact_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d, rp_inc, wp_inc;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       last_acc_q, last_acc_d;

  // maneuver store: RAM read address tracks the next read pointer, so the
  // entry at rp_q is ready in the cycle a pop is processed
  logic       mem_we;
  logic [2:0] mem_rdata;
  logic       byp_q;
  logic [2:0] byp_data_q;
  logic [2:0] head_man, man;

  sca_ram #(
    .Width (3),
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (value_q[2:0]),
    .raddr_i (rp_d),
    .rdata_o (mem_rdata)
  );

  // write to the address being read: forward the new entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= mem_we && (wp_q == rp_d);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= value_q[2:0];
  end

  assign head_man = byp_q ? byp_data_q : mem_rdata;
  assign man      = (head_man > MAX_MANEUVER) ? 3'd0 : head_man;

  assign rp_inc = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign wp_inc = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  // remote reading counts as active away from neutral, compared unwrapped
  logic [8:0] act_hi;
  logic       active;
  assign act_hi = {1'b0, neutral_q} + {2'b00, thresh_q};
  assign active = ({1'b0, value_q} >= act_hi) ||
                  (({1'b0, value_q} + {2'b00, thresh_q}) <= {1'b0, neutral_q});

  logic [7:0]  disp, ang;
  logic [15:0] pwm_x;
  logic [1:0]  kind;
  logic [7:0]  ev;
  logic        two, is_pwm, push, do_clear;
  logic [1:0]  chan_kind;

  assign chan_kind = chan_q ? EV_STEER : EV_SPEED;
  assign pwm_x = {5'd0, value_q, 3'd0} + PWM_BIAS;
  assign disp  = (man < 3'd3) ? neutral_q + {1'b0, dist_off_q}
                              : neutral_q - {1'b0, dist_off_q};

  always_comb begin
    case (man)
      3'd1, 3'd4: ang = neutral_q + {1'b0, turn_off_q};
      3'd2, 3'd5: ang = neutral_q - {1'b0, turn_off_q};
      default:    ang = neutral_q;
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    inact_d    = inact_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    last_acc_d = last_acc_q;
    kind       = EV_NONE;
    ev         = '0;
    two        = 1'b0;
    is_pwm     = 1'b0;
    push       = 1'b0;
    do_clear   = 1'b0;
    if (load) begin
      case (req_type_q)
        REQ_BUS_WRITE: begin
          if (mode_q) begin
            case (bus_reg_q)
              BUS_SPEED: begin
                do_clear = 1'b1;
                kind     = EV_SPEED;
                ev       = value_q;
              end
              BUS_DIRECTION: begin
                do_clear = 1'b1;
                kind     = EV_STEER;
                ev       = value_q;
              end
              BUS_MANEUVER: begin
                if (value_q <= {5'd0, MAX_MANEUVER} && cnt_q < CNT_W'(QUEUE_DEPTH)) begin
                  push       = 1'b1;
                  wp_d       = wp_inc;
                  cnt_d      = cnt_q + 1'b1;
                  last_acc_d = value_q;
                end
              end
              default: ;
            endcase
          end
        end
        REQ_REMOTE: begin
          if (mode_q) begin
            if (active) begin
              do_clear = 1'b1;
              mode_d   = 1'b0;
              kind     = chan_kind;
              ev       = value_q;
            end
          end else begin
            if (active) begin
              inact_d = ticks_q;
            end
            kind = chan_kind;
            ev   = value_q;
          end
        end
        REQ_TICK: begin
          if (inact_q != 8'd0) begin
            inact_d = inact_q - 1'b1;
            if (inact_q == 8'd1) begin
              mode_d = 1'b1;
            end
          end
        end
        REQ_DISP_DONE: begin
          if (cnt_q != '0) begin
            rp_d  = rp_inc;
            cnt_d = cnt_q - 1'b1;
            two   = 1'b1;
          end
        end
        REQ_STEER_POS: begin
          is_pwm = 1'b1;
        end
        default: ;
      endcase
      if (do_clear) begin
        rp_d  = '0;
        wp_d  = '0;
        cnt_d = '0;
      end
    end
  end

  assign mem_we = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      inact_q    <= RST_TICKS;
      rp_q       <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
      last_acc_q <= '0;
    end else begin
      mode_q     <= mode_d;
      inact_q    <= inact_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      cnt_q      <= cnt_d;
      last_acc_q <= last_acc_d;
    end
  end

  // ---------------- result assembly ----------------
  res_t r0, r1;

  always_comb begin
    r0.kind      = two ? EV_DISP : kind;
    r0.value     = two ? disp : ev;
    r0.internal  = two;
    r0.pwm_valid = is_pwm;
    r0.pwm_lo    = is_pwm ? PWM_LOW_BASE + pwm_x : 16'd0;
    r0.pwm_hi    = is_pwm ? PWM_HIGH_BASE - pwm_x : 16'd0;
    r0.mode      = mode_d;
    r0.pending   = cnt_d;
    r0.inact     = inact_d;
    r0.last_man  = last_acc_d;
    r0.last      = !two;

    r1           = r0;
    r1.kind      = EV_STEER;
    r1.value     = ang;
    r1.pwm_valid = 1'b0;
    r1.pwm_lo    = 16'd0;
    r1.pwm_hi    = 16'd0;
    r1.last      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= two;
    end else if (out_fire) begin
      out_valid_q  <= pend_valid_q;
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= r0;
      pend_q <= r1;
    end else if (out_fire && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign res_o.valid                  = out_valid_q;
  assign res_o.event_kind             = out_q.kind;
  assign res_o.event_value            = out_q.value;
  assign res_o.to_internal_queue      = out_q.internal;
  assign res_o.pwm_valid              = out_q.pwm_valid;
  assign res_o.pwm_low_time           = out_q.pwm_lo;
  assign res_o.pwm_high_time          = out_q.pwm_hi;
  assign res_o.control_mode           = out_q.mode;
  assign res_o.pending_count          = out_q.pending;
  assign res_o.inactivity_left        = out_q.inact;
  assign res_o.last_received_maneuver = out_q.last_man;
  assign res_o.last_of_run            = out_q.last;

  // ---------------- assertions ----------------
  `SCA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH))
  `SCA_ASSERT_IMP(a_pend_behind_out, pend_valid_q, out_valid_q && !out_q.last)
  `SCA_ASSERT_NEXT(a_pop_pairs, load && two, pend_valid_q && out_q.kind == EV_DISP)
  `SCA_ASSERT_IMP(a_empty_ptrs, cnt_q == '0, rp_q == wp_q)

endmodule

`default_nettype wire

// ===== test/sca_demand_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Steering command arbiter demand checker
// Watches both channels and the register port, predicts the result items of
// every accepted request and compares them, in order, with what the block
// emits. Reports the mismatch count and the number of results still owed.
// ----------------------------------------------------------------------------
module sca_demand_checker
  import sca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sca_req_if                    req_i,
  sca_res_if                    res_i,
  output int                    mismatches_o,
  output int                    outstanding_o
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ev_value;
    logic        internal;
    logic        pwm_valid;
    logic [15:0] pwm_low;
    logic [15:0] pwm_high;
    logic        bus_mode;
    logic [4:0]  pending;
    logic [7:0]  countdown;
    logic [7:0]  last_maneuver;
    logic        last;
  } demand_t;

  // register mirror
  logic [7:0] neutral;
  logic [6:0] threshold;
  logic [7:0] reload;
  logic [6:0] dist_off;
  logic [6:0] turn_off;

  // arbiter state mirror
  logic       bus_mode;
  logic [7:0] countdown;
  logic [2:0] maneuvers [DEPTH];
  logic [3:0] rd_ptr;
  logic [3:0] wr_ptr;
  logic [4:0] fill;
  logic [7:0] last_maneuver;

  demand_t demand_q [$];

  function automatic bit is_active(input logic [7:0] val);
    int n;
    int t;
    int x;
    n = neutral;
    t = threshold;
    x = val;
    return (x >= n + t) || (x <= n - t);
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  task automatic flush_queue();
    rd_ptr = '0;
    wr_ptr = '0;
    fill   = '0;
  endtask

  task automatic stamp_status(inout demand_t d);
    d.bus_mode      = bus_mode;
    d.pending       = fill;
    d.countdown     = countdown;
    d.last_maneuver = last_maneuver;
  endtask

  // Work out the result items of one accepted request and queue them.
  task automatic predict_demands(input logic [2:0] rtype, input logic [7:0] breg,
                                 input logic chan, input logic [7:0] val);
    demand_t    d;
    demand_t    first;
    bit         popped;
    logic [2:0] man;
    logic [7:0] disp;
    logic [7:0] ang;
    logic [15:0] span;
    d      = '0;
    first  = '0;
    popped = 1'b0;
    d.last = 1'b1;
    case (rtype)
      REQ_BUS_WRITE: begin
        if (bus_mode) begin
          if (breg == BUS_SPEED) begin
            flush_queue();
            d.kind = EV_SPEED;
            d.ev_value = val;
          end else if (breg == BUS_DIRECTION) begin
            flush_queue();
            d.kind = EV_STEER;
            d.ev_value = val;
          end else if (breg == BUS_MANEUVER && val <= MAX_MANEUVER && fill < DEPTH) begin
            maneuvers[wr_ptr] = val[2:0];
            wr_ptr = (wr_ptr == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
            fill++;
            last_maneuver = val;
          end
        end
      end
      REQ_REMOTE: begin
        if (bus_mode) begin
          // remote takes over; countdown keeps its value
          if (is_active(val)) begin
            flush_queue();
            bus_mode = 1'b0;
            d.kind = chan ? EV_STEER : EV_SPEED;
            d.ev_value = val;
          end
        end else begin
          if (is_active(val)) countdown = reload;
          d.kind = chan ? EV_STEER : EV_SPEED;
          d.ev_value = val;
        end
      end
      REQ_TICK: begin
        if (countdown != 0) begin
          countdown--;
          if (countdown == 0) bus_mode = 1'b1;
        end
      end
      REQ_DISP_DONE: begin
        if (fill != 0) begin
          man = maneuvers[rd_ptr];
          rd_ptr = (rd_ptr == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
          fill--;
          // table entries wrap modulo 256
          disp = (man < 3) ? neutral + dist_off : neutral - dist_off;
          case (man % 3)
            0:       ang = neutral;
            1:       ang = neutral + turn_off;
            default: ang = neutral - turn_off;
          endcase
          first.kind     = EV_DISP;
          first.ev_value = disp;
          first.internal = 1'b1;
          first.last     = 1'b0;
          d.kind         = EV_STEER;
          d.ev_value     = ang;
          d.internal     = 1'b1;
          popped         = 1'b1;
        end else begin
          fill = '0;
        end
      end
      REQ_STEER_POS: begin
        span = {val, 3'b000} + PWM_BIAS;
        d.pwm_valid = 1'b1;
        d.pwm_low   = PWM_LOW_BASE + span;
        d.pwm_high  = PWM_HIGH_BASE - span;
      end
      default: ;
    endcase
    if (popped) begin
      stamp_status(first);
      demand_q.push_back(first);
    end
    stamp_status(d);
    demand_q.push_back(d);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    demand_t got;
    demand_t want;
    int      errs;
    if (!rst_ni) begin
      neutral       = RST_NEUTRAL;
      threshold     = RST_THRESHOLD;
      reload        = RST_TICKS;
      dist_off      = RST_DIST_OFF;
      turn_off      = RST_TURN_OFF;
      bus_mode      = 1'b0;
      countdown     = RST_TICKS;
      last_maneuver = '0;
      mismatches_o  = 0;
      flush_queue();
      demand_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NEUTRAL:   neutral   = cfg_data_i;
          CFG_THRESHOLD: threshold = cfg_data_i[6:0];
          CFG_TICKS:     reload    = cfg_data_i;
          CFG_DIST_OFF:  dist_off  = cfg_data_i[6:0];
          CFG_TURN_OFF:  turn_off  = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready)
        predict_demands(req_i.req_type, req_i.bus_register, req_i.remote_channel,
                        req_i.value);
      if (res_i.valid && res_i.ready) begin
        if (demand_q.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches_o++;
        end else begin
          want = demand_q.pop_front();
          got.kind          = res_i.event_kind;
          got.ev_value      = res_i.event_value;
          got.internal      = res_i.to_internal_queue;
          got.pwm_valid     = res_i.pwm_valid;
          got.pwm_low       = res_i.pwm_low_time;
          got.pwm_high      = res_i.pwm_high_time;
          got.bus_mode      = res_i.control_mode;
          got.pending       = res_i.pending_count;
          got.countdown     = res_i.inactivity_left;
          got.last_maneuver = res_i.last_received_maneuver;
          got.last          = res_i.last_of_run;
          errs = field_diff("event_kind", want.kind, got.kind)
               + field_diff("event_value", want.ev_value, got.ev_value)
               + field_diff("to_internal_queue", want.internal, got.internal)
               + field_diff("pwm_valid", want.pwm_valid, got.pwm_valid)
               + field_diff("pwm_low_time", want.pwm_low, got.pwm_low)
               + field_diff("pwm_high_time", want.pwm_high, got.pwm_high)
               + field_diff("control_mode", want.bus_mode, got.bus_mode)
               + field_diff("pending_count", want.pending, got.pending)
               + field_diff("inactivity_left", want.countdown, got.countdown)
               + field_diff("last_received_maneuver", want.last_maneuver,
                            got.last_maneuver)
               + field_diff("last_of_run", want.last, got.last);
          mismatches_o += errs;
        end
      end
    end
    outstanding_o = demand_q.size();
  end

endmodule

// ===== test/steering_command_arbiter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Steering command arbiter testbench
// Runs a short directed pass over the reset settings and the bus-mode corner
// cases, then phases of random control sessions under changing register
// settings and idling patterns. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module steering_command_arbiter_unit_tb;
  import sca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 110;

  // Register settings per random phase. The extremes are spread over the
  // phases: neutral 0/255, threshold 0/127, reload 0/1/255, offsets 0/127.
  localparam logic [7:0] PH_NEUTRAL [PHASES] = '{8'd128, 8'd0, 8'd255, 8'd200, 8'd77, 8'd128};
  localparam logic [6:0] PH_THRESH  [PHASES] = '{7'd10, 7'd127, 7'd0, 7'd60, 7'd5, 7'd1};
  localparam logic [7:0] PH_TICKS   [PHASES] = '{8'd3, 8'd1, 8'd2, 8'd255, 8'd0, 8'd35};
  localparam logic [6:0] PH_DIST    [PHASES] = '{7'd95, 7'd127, 7'd0, 7'd127, 7'd33, 7'd64};
  localparam logic [6:0] PH_TURN    [PHASES] = '{7'd90, 7'd127, 7'd0, 7'd1, 7'd100, 7'd45};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sca_req_if              req_if ();
  sca_res_if #(.CntW(5))  res_if ();

  int          mismatches;
  int          outstanding;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;

  // stimulus-side copy of the registers, used to aim remote readings
  logic [7:0] cur_neutral = RST_NEUTRAL;
  logic [6:0] cur_thresh  = RST_THRESHOLD;
  logic [7:0] cur_ticks   = RST_TICKS;

  steering_command_arbiter_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  sca_demand_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .req_i         (req_if),
    .res_i         (res_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure, redrawn every cycle.
  always @(negedge clk)
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

  // One request transfer. Called and returning just after a falling edge;
  // valid is only lowered when the sender actually idles, so a back-to-back
  // item never sees valid dropped and raised in the same step.
  task automatic send_item(input logic [2:0] rtype, input logic [7:0] breg,
                           input logic chan, input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= rtype;
    req_if.bus_register   <= breg;
    req_if.remote_channel <= chan;
    req_if.value          <= val;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every owed result has been taken.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // All five registers, one write per cycle; only called while drained.
  task automatic load_settings(input logic [7:0] neutral, input logic [6:0] thresh,
                               input logic [7:0] ticks, input logic [6:0] disp_off,
                               input logic [6:0] turn);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NEUTRAL;
    cfg_data <= neutral;
    @(negedge clk);
    cfg_idx  <= CFG_THRESHOLD;
    cfg_data <= {1'b0, thresh};
    @(negedge clk);
    cfg_idx  <= CFG_TICKS;
    cfg_data <= ticks;
    @(negedge clk);
    cfg_idx  <= CFG_DIST_OFF;
    cfg_data <= {1'b0, disp_off};
    @(negedge clk);
    cfg_idx  <= CFG_TURN_OFF;
    cfg_data <= {1'b0, turn};
    @(negedge clk);
    cfg_we      <= 1'b0;
    cur_neutral = neutral;
    cur_thresh  = thresh;
    cur_ticks   = ticks;
  endtask

  // Reading far enough from neutral to count as active. One side of the
  // band always fits in 0..255 since the threshold is at most 127.
  function automatic logic [7:0] active_value();
    int n;
    int t;
    n = cur_neutral;
    t = cur_thresh;
    if (n + t <= 255 && (n < t || $urandom_range(1)))
      return $urandom_range(255, n + t);
    return $urandom_range(n - t, 0);
  endfunction

  // Reading inside the neutral band; caller makes sure the band is not empty.
  function automatic logic [7:0] quiet_value();
    int lo;
    int hi;
    lo = int'(cur_neutral) - int'(cur_thresh) + 1;
    hi = int'(cur_neutral) + int'(cur_thresh) - 1;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    return $urandom_range(hi, lo);
  endfunction

  // Fully random request, including the unused request types.
  task automatic send_noise();
    send_item($urandom_range(7),
              $urandom_range(1) ? $urandom_range(255) : $urandom_range(3),
              $urandom_range(1), $urandom_range(255));
  endtask

  // One bus session: grab control back to remote and reload the countdown,
  // tick it out so the bus takes over, queue maneuvers (some out of range,
  // sometimes enough to overflow the queue), pop them, and maybe end with a
  // speed/direction write or a remote takeover.
  task automatic run_bus_session();
    int n_man;
    int n_pop;
    send_item(REQ_REMOTE, $urandom_range(255), $urandom_range(1), active_value());
    send_item(REQ_REMOTE, $urandom_range(255), $urandom_range(1), active_value());
    repeat (cur_ticks)
      send_item(REQ_TICK, $urandom_range(255), $urandom_range(1), $urandom_range(255));
    n_man = ($urandom_range(3) == 0) ? $urandom_range(22, 16) : $urandom_range(8);
    for (int i = 0; i < n_man; i++) begin
      case ($urandom_range(19))
        0: send_item(REQ_DISP_DONE, $urandom_range(255), $urandom_range(1),
                     $urandom_range(255));
        1: send_item(REQ_STEER_POS, $urandom_range(255), $urandom_range(1),
                     $urandom_range(255));
        2: begin
          // neutral reading in bus mode is dropped
          if (cur_thresh != 0)
            send_item(REQ_REMOTE, $urandom_range(255), $urandom_range(1), quiet_value());
        end
        3: send_item(REQ_BUS_WRITE, $urandom_range(255, 3), $urandom_range(1),
                     $urandom_range(255));
        default: send_item(REQ_BUS_WRITE, BUS_MANEUVER, $urandom_range(1),
                           ($urandom_range(9) == 0) ? $urandom_range(255, 6)
                                                    : $urandom_range(5));
      endcase
    end
    n_pop = $urandom_range(n_man + 2);
    repeat (n_pop)
      send_item(REQ_DISP_DONE, $urandom_range(255), $urandom_range(1), $urandom_range(255));
    case ($urandom_range(5))
      0: send_item(REQ_BUS_WRITE, BUS_SPEED, $urandom_range(1), $urandom_range(255));
      1: send_item(REQ_BUS_WRITE, BUS_DIRECTION, $urandom_range(1), $urandom_range(255));
      2: wait_drained();
      default: ;
    endcase
    if ($urandom_range(1))
      send_item(REQ_REMOTE, $urandom_range(255), $urandom_range(1), active_value());
  endtask

  initial begin
    int unsigned phase_start;
    rst_n                 = 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_data              <= '0;
    req_if.valid          <= 1'b0;
    req_if.req_type       <= '0;
    req_if.bus_register   <= '0;
    req_if.remote_channel <= 1'b0;
    req_if.value          <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: reset register values, remote in control ----
    send_item(REQ_REMOTE, 8'd0, 1'b0, 8'd255);     // active, reloads countdown
    send_item(REQ_REMOTE, 8'd0, 1'b1, 8'd128);     // neutral, still forwarded
    send_item(REQ_REMOTE, 8'd0, 1'b1, 8'd0);
    send_item(REQ_STEER_POS, 8'd0, 1'b0, 8'd0);
    send_item(REQ_STEER_POS, 8'd0, 1'b0, 8'd255);
    send_item(3'd5, 8'd0, 1'b0, 8'd0);             // unused request types
    send_item(3'd7, 8'hff, 1'b1, 8'hff);
    send_item(REQ_BUS_WRITE, BUS_SPEED, 1'b0, 8'd77);  // ignored in remote mode
    send_item(REQ_DISP_DONE, 8'd0, 1'b0, 8'd0);    // pop with empty queue
    send_item(REQ_TICK, 8'd0, 1'b0, 8'd0);
    wait_drained();

    // ---- directed: one-tick reload to reach bus mode quickly ----
    load_settings(8'd128, 7'd10, 8'd1, 7'd95, 7'd90);
    send_item(REQ_REMOTE, 8'd0, 1'b0, 8'd0);       // reload to 1
    send_item(REQ_TICK, 8'd0, 1'b0, 8'd0);         // hits zero, bus takes over
    send_item(REQ_TICK, 8'd0, 1'b0, 8'd0);         // countdown already at zero
    for (int m = 0; m <= MAX_MANEUVER; m++)
      send_item(REQ_BUS_WRITE, BUS_MANEUVER, 1'b0, 8'(m));
    send_item(REQ_BUS_WRITE, BUS_MANEUVER, 1'b0, 8'd6);   // out of range, dropped
    send_item(REQ_BUS_WRITE, 8'd200, 1'b0, 8'd1);         // unknown register
    send_item(REQ_DISP_DONE, 8'd0, 1'b0, 8'd0);
    send_item(REQ_BUS_WRITE, BUS_SPEED, 1'b0, 8'haa);     // clears the queue
    send_item(REQ_BUS_WRITE, BUS_MANEUVER, 1'b0, 8'd3);
    send_item(REQ_BUS_WRITE, BUS_DIRECTION, 1'b1, 8'h55); // clears again
    send_item(REQ_REMOTE, 8'd0, 1'b0, 8'd130);     // neutral in bus mode, dropped
    send_item(REQ_REMOTE, 8'd0, 1'b1, 8'd0);       // remote takes control back
    wait_drained();

    // ---- random phases ----
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      load_settings(PH_NEUTRAL[p], PH_THRESH[p], PH_TICKS[p], PH_DIST[p], PH_TURN[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(6, 1)) send_noise();
        else
          run_bus_session();
      end
      wait_drained();
    end

    // let any stray result show up before the verdict
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_if.valid  <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sca_pkg.sv
design/sca_if.sv
design/sca_ram.sv
design/steering_command_arbiter_unit.sv
test/sca_demand_checker.sv
test/steering_command_arbiter_unit_tb.sv
